/* src/rwp_pkg.sv */
// ----------------------------------------------------------------------------
// rwp_pkg: shared types and constants for the WAV stream parser
// Status codes, chunk tags and the event record that passes from the byte
// parser through the event queue to the result emitter.
// ----------------------------------------------------------------------------
package rwp_pkg;

   // Status codes of the final status result
   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_BAD_HEADER    = 3'd1,
      ST_BAD_FORMAT    = 3'd2,
      ST_MISSING_CHUNK = 3'd3,
      ST_TRUNCATED     = 3'd4
   } status_type;

   // Result kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Four-character codes, first byte in the low lane
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   // Field values the fmt chunk must carry
   localparam logic [31:0] FMT_PCM      = 32'd1;
   localparam logic [31:0] FMT_MONO     = 32'd1;
   localparam logic [31:0] FMT_BITS     = 32'd16;
   localparam logic [31:0] FMT_BODY_LEN = 32'd16;

   localparam logic [31:0] RATE_RESET = 32'd16000;

   // Event queue geometry
   localparam int EVT_DEPTH = 4;
   localparam int EVT_PTR_W = $clog2(EVT_DEPTH);
   localparam int EVT_CNT_W = $clog2(EVT_DEPTH + 1);

   // Results caused by one byte: at most one sample and one status
   typedef struct packed {
      logic        has_sample;
      logic [15:0] sample;
      logic        has_status;
      status_type  status;
   } event_type;

endpackage

/* src/rwp_parser.sv */
// ----------------------------------------------------------------------------
// rwp_parser: byte-level RIFF/WAVE parser (front end)
// Walks header, chunk headers, fmt fields, skipped bodies and sample data one
// byte per valid cycle and emits one event for each byte that causes results.
// ----------------------------------------------------------------------------
module rwp_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_valid,
   input  logic [7:0]          data_byte,
   input  logic                end_of_file,
   input  logic                csr_write_enable,
   input  logic [31:0]         csr_write_data,
   output logic                evt_valid,
   output rwp_pkg::event_type  evt
);
   import rwp_pkg::*;

   typedef enum logic [2:0] {
      PH_RIFF,
      PH_CHUNK,
      PH_FMT,
      PH_SKIP,
      PH_DATA
   } phase_type;

   // Byte offsets within the headers
   localparam logic [3:0] RIFF_LAST  = 4'd11;
   localparam logic [3:0] WAVE_FIRST = 4'd8;
   localparam logic [3:0] CHUNK_LAST = 4'd7;
   localparam logic [3:0] FMT_LAST   = 4'd15;
   localparam logic [3:0] BITS_FIRST = 4'd14;

   phase_type   phase_ff, phase_in;
   logic [3:0]  idx_ff, idx_in;
   logic [31:0] len_ff, len_in;
   logic [1:0]  shift_ff, shift_in;
   logic [31:0] fval_ff, fval_in;
   logic [31:0] tag_ff, tag_in;
   logic        mis_ff, mis_in;
   logic        fmt_seen_ff, fmt_seen_in;
   logic [31:0] rem_ff, rem_in;
   logic [7:0]  hold_ff, hold_in;
   logic        done_ff, done_in;
   logic [31:0] rate_ff, rate_in;

   logic        mis;
   logic [31:0] fv_base;
   logic [1:0]  fs_base;
   logic [31:0] fv_new;
   logic [31:0] tag_new;
   logic [31:0] len_new;
   logic [31:0] dec;

   // Parse one byte
   always_comb begin
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      len_in      = len_ff;
      shift_in    = shift_ff;
      fval_in     = fval_ff;
      tag_in      = tag_ff;
      mis_in      = mis_ff;
      fmt_seen_in = fmt_seen_ff;
      rem_in      = rem_ff;
      hold_in     = hold_ff;
      done_in     = done_ff;
      rate_in     = csr_write_enable ? csr_write_data : rate_ff;
      evt         = '0;
      mis         = mis_ff;
      fv_base     = fval_ff;
      fs_base     = shift_ff;
      fv_new      = fval_ff;
      tag_new     = tag_ff;
      len_new     = len_ff;
      dec         = len_ff;

      if (byte_valid) begin
         if (!done_ff) begin
            unique case (phase_ff)
               PH_RIFF: begin
                  if (idx_ff < 4'd4 && data_byte != TAG_RIFF[{idx_ff[1:0], 3'b000} +: 8]) begin
                     mis = 1'b1;
                  end
                  if (idx_ff >= WAVE_FIRST && data_byte != TAG_WAVE[{idx_ff[1:0], 3'b000} +: 8])
                  begin
                     mis = 1'b1;
                  end
                  mis_in = mis;
                  if (idx_ff == RIFF_LAST) begin
                     idx_in = '0;
                     if (mis) begin
                        evt.has_status = 1'b1;
                        evt.status     = ST_BAD_HEADER;
                        done_in        = 1'b1;
                     end else begin
                        phase_in = PH_CHUNK;
                     end
                  end else begin
                     idx_in = idx_ff + 4'd1;
                  end
               end
               PH_CHUNK: begin
                  // assemble id then length, little-endian
                  if (idx_ff == '0) begin
                     tag_new = '0;
                     len_new = '0;
                  end
                  if (idx_ff < 4'd4) begin
                     tag_new[{idx_ff[1:0], 3'b000} +: 8] = data_byte;
                  end else begin
                     len_new[{idx_ff[1:0], 3'b000} +: 8] = data_byte;
                  end
                  tag_in = tag_new;
                  len_in = len_new;
                  if (idx_ff == CHUNK_LAST) begin
                     idx_in = '0;
                     if (tag_new == TAG_FMT) begin
                        phase_in = PH_FMT;
                        mis_in   = 1'b0;
                        fval_in  = '0;
                        shift_in = '0;
                     end else if (tag_new == TAG_DATA) begin
                        if (!fmt_seen_ff) begin
                           evt.has_status = 1'b1;
                           evt.status     = ST_MISSING_CHUNK;
                           done_in        = 1'b1;
                        end else begin
                           rem_in = len_new;
                           if (len_new == '0) begin
                              evt.has_status = 1'b1;
                              evt.status     = ST_OK;
                              done_in        = 1'b1;
                           end else begin
                              phase_in = PH_DATA;
                           end
                        end
                     end else if (len_new != '0) begin
                        phase_in = PH_SKIP;
                     end
                  end else begin
                     idx_in = idx_ff + 4'd1;
                  end
               end
               PH_FMT: begin
                  // restart the field at each checked field boundary
                  if (idx_ff == 4'd0 || idx_ff == 4'd2 || idx_ff == 4'd4 ||
                      idx_ff == BITS_FIRST) begin
                     fv_base = '0;
                     fs_base = '0;
                  end
                  fv_new   = fv_base;
                  shift_in = fs_base;
                  if (idx_ff < WAVE_FIRST || idx_ff >= BITS_FIRST) begin
                     fv_new   = fv_base | ({24'd0, data_byte} << {fs_base, 3'b000});
                     shift_in = fs_base + 2'd1;
                  end
                  fval_in = fv_new;
                  if (idx_ff == 4'd1 && fv_new != FMT_PCM) mis = 1'b1;
                  if (idx_ff == 4'd3 && fv_new != FMT_MONO) mis = 1'b1;
                  if (idx_ff == 4'd7 && fv_new != rate_ff) mis = 1'b1;
                  if (idx_ff == FMT_LAST && fv_new != FMT_BITS) mis = 1'b1;
                  mis_in = mis;
                  if (idx_ff == FMT_LAST) begin
                     idx_in = '0;
                     if (mis) begin
                        evt.has_status = 1'b1;
                        evt.status     = ST_BAD_FORMAT;
                        done_in        = 1'b1;
                     end else begin
                        fmt_seen_in = 1'b1;
                        if (len_ff > FMT_BODY_LEN) begin
                           len_in   = len_ff - FMT_BODY_LEN;
                           phase_in = PH_SKIP;
                        end else begin
                           phase_in = PH_CHUNK;
                        end
                     end
                  end else begin
                     idx_in = idx_ff + 4'd1;
                  end
               end
               PH_SKIP: begin
                  if (len_ff != '0) dec = len_ff - 32'd1;
                  len_in = dec;
                  if (dec == '0) begin
                     phase_in = PH_CHUNK;
                     idx_in   = '0;
                  end
               end
               PH_DATA: begin
                  // pair bytes into one sample
                  if (idx_ff == '0) begin
                     hold_in = data_byte;
                     idx_in  = 4'd1;
                  end else begin
                     evt.has_sample = 1'b1;
                     evt.sample     = {data_byte, hold_ff};
                     idx_in         = '0;
                  end
                  dec = rem_ff;
                  if (rem_ff != '0) dec = rem_ff - 32'd1;
                  rem_in = dec;
                  if (dec == '0) begin
                     evt.has_status = 1'b1;
                     evt.status     = ST_OK;
                     done_in        = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end

         // close the file: report where it stopped if no status was given yet, then clear parse state
         if (end_of_file) begin
            if (!done_in) begin
               evt.has_status = 1'b1;
               unique case (phase_in)
                  PH_RIFF: evt.status = ST_BAD_HEADER;
                  PH_FMT:  evt.status = ST_BAD_FORMAT;
                  PH_DATA: evt.status = ST_TRUNCATED;
                  default: evt.status = ST_MISSING_CHUNK;
               endcase
            end
            phase_in    = PH_RIFF;
            idx_in      = '0;
            len_in      = '0;
            shift_in    = '0;
            fval_in     = '0;
            tag_in      = '0;
            mis_in      = 1'b0;
            fmt_seen_in = 1'b0;
            rem_in      = '0;
            hold_in     = '0;
            done_in     = 1'b0;
         end
      end
   end

   assign evt_valid = byte_valid && (evt.has_sample || evt.has_status);

   // Hold parse state and the rate register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_RIFF;
         idx_ff      <= '0;
         len_ff      <= '0;
         shift_ff    <= '0;
         fval_ff     <= '0;
         tag_ff      <= '0;
         mis_ff      <= 1'b0;
         fmt_seen_ff <= 1'b0;
         rem_ff      <= '0;
         hold_ff     <= '0;
         done_ff     <= 1'b0;
         rate_ff     <= RATE_RESET;
      end else begin
         phase_ff    <= phase_in;
         idx_ff      <= idx_in;
         len_ff      <= len_in;
         shift_ff    <= shift_in;
         fval_ff     <= fval_in;
         tag_ff      <= tag_in;
         mis_ff      <= mis_in;
         fmt_seen_ff <= fmt_seen_in;
         rem_ff      <= rem_in;
         hold_ff     <= hold_in;
         done_ff     <= done_in;
         rate_ff     <= rate_in;
      end
   end

endmodule

/* src/rwp_event_fifo.sv */
// ----------------------------------------------------------------------------
// rwp_event_fifo: short event queue between parser and emitter
// Registered circular buffer with a fill count; read data is the head entry.
// ----------------------------------------------------------------------------
module rwp_event_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_en,
   input  rwp_pkg::event_type  push_data,
   input  logic                pop_en,
   output logic                fifo_full,
   output logic                fifo_empty,
   output rwp_pkg::event_type  head
);
   import rwp_pkg::*;

   event_type              mem_ff [EVT_DEPTH];
   logic [EVT_PTR_W-1:0]   wr_ff, wr_in;
   logic [EVT_PTR_W-1:0]   rd_ff, rd_in;
   logic [EVT_CNT_W-1:0]   cnt_ff, cnt_in;

   assign fifo_full  = (cnt_ff == EVT_CNT_W'(EVT_DEPTH));
   assign fifo_empty = (cnt_ff == '0);
   assign head       = mem_ff[rd_ff];

   // Advance pointers and count
   always_comb begin
      wr_in  = push_en ? wr_ff + EVT_PTR_W'(1) : wr_ff;
      rd_in  = pop_en ? rd_ff + EVT_PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (push_en && !pop_en) cnt_in = cnt_ff + EVT_CNT_W'(1);
      if (!push_en && pop_en) cnt_in = cnt_ff - EVT_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push_en) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* src/rwp_emitter.sv */
// ----------------------------------------------------------------------------
// rwp_emitter: result sequencer (back end)
// Takes one event at a time and presents its sample and status results in
// order, marking the final one of the event.
// ----------------------------------------------------------------------------
module rwp_emitter (
   input  logic                clock,
   input  logic                reset,
   input  logic                fifo_empty,
   input  rwp_pkg::event_type  head,
   output logic                fifo_pop,
   output logic                empty,
   input  logic                pop,
   output logic                rsp_kind,
   output logic [15:0]         rsp_sample,
   output logic [2:0]          rsp_status,
   output logic                rsp_last
);
   import rwp_pkg::*;

   event_type cur_ff, cur_in;
   logic      valid_ff, valid_in;
   logic      second_ff, second_in;

   logic show_sample;
   logic beat_done;
   logic split;
   logic load;

   // Drive the current result
   assign show_sample = cur_ff.has_sample && !second_ff;
   assign rsp_kind    = show_sample ? KIND_SAMPLE : KIND_STATUS;
   assign rsp_sample  = show_sample ? cur_ff.sample : 16'd0;
   assign rsp_status  = show_sample ? 3'(ST_OK) : 3'(cur_ff.status);
   assign rsp_last    = show_sample ? !cur_ff.has_status : 1'b1;
   assign empty       = !valid_ff;

   // Step through the event, refill from the queue
   assign beat_done = valid_ff && pop;
   assign split     = show_sample && cur_ff.has_status;
   assign load      = !fifo_empty && (!valid_ff || (beat_done && !split));
   assign fifo_pop  = load;

   always_comb begin
      cur_in    = cur_ff;
      valid_in  = valid_ff;
      second_in = second_ff;
      if (load) begin
         cur_in    = head;
         valid_in  = 1'b1;
         second_in = 1'b0;
      end else if (beat_done) begin
         if (split) begin
            second_in = 1'b1;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   // Hold event payload
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

/* src/riff_wave_pcm_stream_parser_unit.sv */
// ----------------------------------------------------------------------------
// riff_wave_pcm_stream_parser_unit: WAV byte stream parser, 16-bit mono PCM
// Checks the RIFF/WAVE header and fmt chunk, skips unknown chunks and emits
// one signed sample per data byte pair, then one status result per file.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive req_data_byte and req_end_of_file with push; a beat is
//   taken at a clock edge where push is high and full is low. One byte per
//   cycle is sustained while full stays low; full rises only when the four-entry
//   event queue between parser and emitter is full.
//   Result queue: while empty is low the oldest result is on the rsp_ ports;
//   pop takes it. A result reaches the rsp_ ports through the event queue and
//   then the emitter's current-event register, after the edge that takes its byte.
//   A byte that causes both a sample and a status holds the result side for
//   two beats; every other result takes one beat.
//   rsp_last marks the final result caused by one byte.
//   When pop stays low, results back up into the event queue and full rises
//   once it fills; nothing is dropped.
//   csr_write_data is loaded into the required sample rate on any cycle with
//   csr_write_enable high; write it only while the block is idle.
//   Reset clears the parser, the queue and the emitter; the rate register
//   returns to 16000. The byte marked end_of_file returns the parser to the
//   header phase for the next file.
// ----------------------------------------------------------------------------
module riff_wave_pcm_stream_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_kind,
   output logic signed [15:0] rsp_sample,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);
   import rwp_pkg::*;

   logic      fifo_full;
   logic      fifo_empty;
   logic      fifo_pop;
   logic      evt_valid;
   logic      accept;
   event_type evt;
   event_type head;
   logic [15:0] sample_bits;

   // Take a byte when the event queue has room
   assign full       = fifo_full;
   assign accept     = push && !fifo_full;
   assign rsp_sample = signed'(sample_bits);

   rwp_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .byte_valid       (accept),
      .data_byte        (req_data_byte),
      .end_of_file      (req_end_of_file),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .evt_valid        (evt_valid),
      .evt              (evt)
   );

   rwp_event_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_en    (evt_valid),
      .push_data  (evt),
      .pop_en     (fifo_pop),
      .fifo_full  (fifo_full),
      .fifo_empty (fifo_empty),
      .head       (head)
   );

   rwp_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .head       (head),
      .fifo_pop   (fifo_pop),
      .empty      (empty),
      .pop        (pop),
      .rsp_kind   (rsp_kind),
      .rsp_sample (sample_bits),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

endmodule
